// File: hdl/rwfe_pkg.sv
package rwfe_pkg;

  typedef enum logic [1:0] {
    CMD_START    = 2'd0,
    CMD_PAYLOAD  = 2'd1,
    CMD_RESPONSE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    JOB_START   = 2'd0,
    JOB_PAYLOAD = 2'd1,
    JOB_VERDICT = 2'd2
  } job_kind_e;

  localparam logic [7:0]  HDR_SOF   = 8'h7E;
  localparam logic [7:0]  HDR_CMD_H = 8'h00;
  localparam logic [7:0]  HDR_CMD_L = 8'h08;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [7:0]  RESP_ACK  = 8'h02;
  localparam logic [7:0]  RESP_ZERO = 8'h00;
  localparam logic [2:0]  RESP_LAST = 3'd6;

  localparam logic OUT_FRAME   = 1'b0;
  localparam logic OUT_VERDICT = 1'b1;

  // One queued unit of work for the back end; expands to 1..8 results.
  typedef struct packed {
    job_kind_e   kind;
    logic        crc_tail;
    logic        verdict;
    logic [15:0] addr;
    logic [7:0]  len;
    logic [7:0]  data;
  } job_t;

  // CRC-16, poly 0x1021, MSB first, one byte.
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: hdl/rwfe_ifs.sv
interface rwfe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] reg_address;
  logic [7:0]  payload_length;
  logic [7:0]  data_byte;

  modport source (output valid, cmd, reg_address, payload_length, data_byte, input ready);
  modport sink (input valid, cmd, reg_address, payload_length, data_byte, output ready);
endinterface

interface rwfe_out_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] out_byte;
  logic       verdict;
  logic       last;

  modport source (output valid, out_kind, out_byte, verdict, last, input ready);
  modport sink (input valid, out_kind, out_byte, verdict, last, output ready);
endinterface

// File: hdl/rwfe_front.sv
module rwfe_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  rwfe_in_if.sink       in_i,
  input  logic          full_i,
  output logic          push_o,
  output rwfe_pkg::job_t job_o
);
  import rwfe_pkg::*;

  logic [7:0] left_q, left_d;
  logic [2:0] ridx_q, ridx_d;
  logic       rbad_q, rbad_d;
  logic       take;
  logic       bad_n;

  assign in_i.ready = !full_i;
  assign take = in_i.valid && !full_i;

  always_comb begin
    left_d = left_q;
    ridx_d = ridx_q;
    rbad_d = rbad_q;
    push_o = 1'b0;
    bad_n  = rbad_q;
    job_o.kind     = JOB_START;
    job_o.crc_tail = 1'b0;
    job_o.verdict  = 1'b0;
    job_o.addr     = in_i.reg_address;
    job_o.len      = in_i.payload_length;
    job_o.data     = in_i.data_byte;
    case (in_i.cmd)
      CMD_START: begin
        push_o         = take;
        job_o.crc_tail = (in_i.payload_length == 8'd0);
        if (take) begin
          left_d = in_i.payload_length;
          ridx_d = '0;
          rbad_d = 1'b0;
        end
      end
      CMD_PAYLOAD: begin
        job_o.kind     = JOB_PAYLOAD;
        job_o.crc_tail = (left_q == 8'd1);
        // stray payload bytes are dropped
        if (left_q != 8'd0) begin
          push_o = take;
          if (take) begin
            left_d = left_q - 8'd1;
          end
        end
      end
      CMD_RESPONSE: begin
        if (ridx_q == 3'd0 && in_i.data_byte != RESP_ACK) begin
          bad_n = 1'b1;
        end
        if ((ridx_q == 3'd1 || ridx_q == 3'd2) && in_i.data_byte != RESP_ZERO) begin
          bad_n = 1'b1;
        end
        job_o.kind    = JOB_VERDICT;
        job_o.verdict = bad_n;
        if (ridx_q == RESP_LAST) begin
          push_o = take;
          if (take) begin
            ridx_d = '0;
            rbad_d = 1'b0;
          end
        end else if (take) begin
          ridx_d = ridx_q + 3'd1;
          rbad_d = bad_n;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      ridx_q <= '0;
      rbad_q <= 1'b0;
    end else begin
      left_q <= left_d;
      ridx_q <= ridx_d;
      rbad_q <= rbad_d;
    end
  end

endmodule

// File: hdl/rwfe_fifo.sv
module rwfe_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rwfe_pkg::job_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output rwfe_pkg::job_t rdata_o
);
  import rwfe_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  job_t          mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: hdl/rwfe_back.sv
module rwfe_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  rwfe_pkg::job_t job_i,
  output logic           pop_o,
  rwfe_out_if.source     out_o
);
  import rwfe_pkg::*;

  logic [2:0]  step_q;
  logic [15:0] crc_q;
  logic        vld_q;
  logic        kind_q, verd_q, last_q;
  logic [7:0]  byte_q;

  logic        load;
  logic [7:0]  sel_byte;
  logic        sel_kind, sel_last;
  logic        crc_en, crc_clr;
  logic [15:0] crc_base;

  assign load  = !empty_i && (!vld_q || out_o.ready);
  assign pop_o = load && sel_last;

  always_comb begin
    sel_byte = '0;
    sel_kind = OUT_FRAME;
    sel_last = 1'b0;
    crc_en   = 1'b0;
    crc_clr  = 1'b0;
    case (job_i.kind)
      JOB_START: begin
        case (step_q)
          3'd0: sel_byte = HDR_SOF;
          3'd1: sel_byte = HDR_CMD_H;
          3'd2: sel_byte = HDR_CMD_L;
          3'd3: begin
            sel_byte = job_i.len;
            crc_en   = 1'b1;
            crc_clr  = 1'b1;
          end
          3'd4: begin
            sel_byte = job_i.addr[15:8];
            crc_en   = 1'b1;
          end
          3'd5: begin
            sel_byte = job_i.addr[7:0];
            crc_en   = 1'b1;
            sel_last = !job_i.crc_tail;
          end
          3'd6: sel_byte = crc_q[15:8];
          default: begin
            sel_byte = crc_q[7:0];
            sel_last = 1'b1;
          end
        endcase
      end
      JOB_PAYLOAD: begin
        case (step_q)
          3'd0: begin
            sel_byte = job_i.data;
            crc_en   = 1'b1;
            sel_last = !job_i.crc_tail;
          end
          3'd1: sel_byte = crc_q[15:8];
          default: begin
            sel_byte = crc_q[7:0];
            sel_last = 1'b1;
          end
        endcase
      end
      default: begin
        sel_kind = OUT_VERDICT;
        sel_last = 1'b1;
      end
    endcase
  end

  assign crc_base = crc_clr ? 16'h0000 : crc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      crc_q  <= '0;
      vld_q  <= 1'b0;
    end else begin
      if (load) begin
        step_q <= sel_last ? 3'd0 : step_q + 3'd1;
        if (crc_en) begin
          crc_q <= crc_byte(crc_base, sel_byte);
        end
        vld_q <= 1'b1;
      end else if (out_o.ready) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= sel_byte;
      kind_q <= sel_kind;
      verd_q <= (sel_kind == OUT_VERDICT) ? job_i.verdict : 1'b0;
      last_q <= sel_last;
    end
  end

  assign out_o.valid    = vld_q;
  assign out_o.out_kind = kind_q;
  assign out_o.out_byte = byte_q;
  assign out_o.verdict  = verd_q;
  assign out_o.last     = last_q;

endmodule

// File: hdl/register_write_frame_encoder_unit.sv
// Register-write frame encoder with reply checker.
// in_i (valid/ready): cmd 0 starts a frame (reg_address, payload_length),
//   cmd 1 carries a payload byte, cmd 2 a received reply byte; cmd 3 and
//   payload bytes beyond the announced length are dropped with no result.
// out_o (valid/ready): frame bytes 7E 00 08 len addr_hi addr_lo, payload
//   echoes, CRC-16 (0x1021, init 0) high byte first; after seven reply bytes
//   one verdict (0 = reply began 02 00 00). last marks an item's final result.
// The front end tracks payload count and reply state and queues a compact
// job per item; while the receiver is ready, the back end expands jobs into
// one result per cycle and runs the CRC, one byte per cycle, as bytes leave.
// An input item passes through the job queue and the back end's output
//   register before its results leave on out_o.
// Throughput: one input per cycle while the job queue (QueueDepth entries)
//   has room; sustained rate is set by the output port at one result per
//   cycle, and a start yields 6 or 8 results, a payload byte 1 or 3.
// Reset clears counters, CRC, queue and output valid.
// A stalled receiver holds the output register; the queue then fills and
//   in_i.ready drops.
module register_write_frame_encoder_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input logic        clk_i,
  input logic        rst_ni,
  rwfe_in_if.sink    in_i,
  rwfe_out_if.source out_o
);
  import rwfe_pkg::*;

  job_t push_job, head_job;
  logic push, pop, full, empty;

  rwfe_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  rwfe_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (head_job)
  );

  rwfe_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .job_i   (head_job),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// File: hdl/rwfe_checker.sv
module rwfe_assert (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_kind_i,
  input logic [7:0] out_byte_i,
  input logic       verdict_i,
  input logic       last_i
);

  // stalled result must stay put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(last_i))
    else $error("output changed while stalled");

  // a verdict is always a lone, final result with a zero byte
  a_verdict_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i |-> last_i && (out_byte_i == 8'h00))
    else $error("malformed verdict result");

  a_frame_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_kind_i |-> !verdict_i)
    else $error("frame byte carries verdict bit");

  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("output valid right after reset");

endmodule

bind register_write_frame_encoder_unit rwfe_assert u_rwfe_assert (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.out_kind),
  .out_byte_i  (out_o.out_byte),
  .verdict_i   (out_o.verdict),
  .last_i      (out_o.last)
);

// File: tb/sv/rwfe_checker.sv
`timescale 1ns / 1ps

module rwfe_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  rwfe_in_if          in_i,
  rwfe_out_if         out_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);
  import rwfe_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       verdict;
    logic       last;
  } frame_result_t;

  frame_result_t frame_expect_q[$];
  frame_result_t staged[8];
  int unsigned   n_staged;

  logic [15:0] crc_q;
  logic [7:0]  payload_left_q;
  logic [2:0]  reply_idx_q;
  logic        reply_bad_q;

  // Bitwise CRC-16, feedback taken from the top bit xor the next data bit.
  function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] acc;
    logic        fb;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[15] ^ b[i];
      acc = {acc[14:0], 1'b0};
      if (fb) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

  task automatic stage(logic kind, logic [7:0] data, logic verdict);
    staged[n_staged] = '{kind, data, verdict, 1'b0};
    n_staged++;
  endtask

  task automatic stage_covered(logic [7:0] b);
    crc_q = crc16_update(crc_q, b);
    stage(OUT_FRAME, b, 1'b0);
  endtask

  task automatic stage_crc();
    stage(OUT_FRAME, crc_q[15:8], 1'b0);
    stage(OUT_FRAME, crc_q[7:0], 1'b0);
  endtask

  task automatic predict_frame_bytes(logic [1:0] cmd, logic [15:0] addr, logic [7:0] len,
                                     logic [7:0] data);
    n_staged = 0;
    case (cmd)
      CMD_START: begin
        reply_idx_q = '0;
        reply_bad_q = 1'b0;
        stage(OUT_FRAME, HDR_SOF, 1'b0);
        stage(OUT_FRAME, HDR_CMD_H, 1'b0);
        stage(OUT_FRAME, HDR_CMD_L, 1'b0);
        crc_q = '0;
        stage_covered(len);
        stage_covered(addr[15:8]);
        stage_covered(addr[7:0]);
        payload_left_q = len;
        if (len == 8'd0) begin
          stage_crc();
        end
      end
      CMD_PAYLOAD: begin
        // payload beyond the announced length is dropped
        if (payload_left_q != 8'd0) begin
          stage_covered(data);
          payload_left_q = payload_left_q - 8'd1;
          if (payload_left_q == 8'd0) begin
            stage_crc();
          end
        end
      end
      CMD_RESPONSE: begin
        if (reply_idx_q == 3'd0 && data != RESP_ACK) begin
          reply_bad_q = 1'b1;
        end
        if ((reply_idx_q == 3'd1 || reply_idx_q == 3'd2) && data != RESP_ZERO) begin
          reply_bad_q = 1'b1;
        end
        if (reply_idx_q == RESP_LAST) begin
          stage(OUT_VERDICT, 8'h00, reply_bad_q);
          reply_idx_q = '0;
          reply_bad_q = 1'b0;
        end else begin
          reply_idx_q = reply_idx_q + 3'd1;
        end
      end
      default: ;
    endcase
    for (int unsigned i = 0; i < n_staged; i++) begin
      if (i == n_staged - 1) begin
        staged[i].last = 1'b1;
      end
      frame_expect_q.push_back(staged[i]);
    end
  endtask

  task automatic check_result();
    frame_result_t got;
    frame_result_t want;
    got = '{out_i.out_kind, out_i.out_byte, out_i.verdict, out_i.last};
    if (frame_expect_q.size() == 0) begin
      errors_o++;
      if (errors_o <= 10) begin
        $display("%0t: unexpected result kind=%0d byte=%02h verdict=%0d last=%0d",
                 $realtime, got.kind, got.data, got.verdict, got.last);
      end
    end else begin
      want = frame_expect_q.pop_front();
      if (got.kind !== want.kind || got.data !== want.data ||
          got.verdict !== want.verdict || got.last !== want.last) begin
        errors_o++;
        if (errors_o <= 10) begin
          $display("%0t: mismatch exp kind=%0d byte=%02h verdict=%0d last=%0d",
                   $realtime, want.kind, want.data, want.verdict, want.last);
          $display("%0t:          got kind=%0d byte=%02h verdict=%0d last=%0d",
                   $realtime, got.kind, got.data, got.verdict, got.last);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q          = '0;
      payload_left_q = '0;
      reply_idx_q    = '0;
      reply_bad_q    = 1'b0;
      frame_expect_q.delete();
      errors_o       = 0;
      pending_o      = 0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        predict_frame_bytes(in_i.cmd, in_i.reg_address, in_i.payload_length, in_i.data_byte);
      end
      if (out_i.valid && out_i.ready) begin
        check_result();
      end
      pending_o = frame_expect_q.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rwfe_pkg::*;

  localparam logic [1:0]  CMD_UNUSED     = 2'd3;
  localparam int unsigned RandomItems    = 100;
  localparam int unsigned QuietFrom      = 85;
  localparam int unsigned LongHoldAt     = 40;
  localparam int unsigned LongHoldCycles = 120;
  localparam int unsigned DrainCycles    = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned mismatch_count;
  int unsigned results_pending;
  int unsigned n_sent;
  int unsigned n_counted;
  int unsigned tx_gap_pct;
  int unsigned rx_gap_pct;
  logic        quiet;

  rwfe_in_if  in_ch ();
  rwfe_out_if out_ch ();

  always #10 clk_i = ~clk_i;

  register_write_frame_encoder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  rwfe_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_i     (out_ch),
    .errors_o  (mismatch_count),
    .pending_o (results_pending)
  );

  initial begin
    #2_000_000;
    $display("register_write_frame_encoder_unit test failed");
    $finish;
  end

  function automatic int unsigned pick_gap_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 20;
      default: return 50;
    endcase
  endfunction

  // Present one item and hold it until the transfer; ready is sampled mid-cycle.
  task automatic send(logic [1:0] cmd, logic [15:0] addr, logic [7:0] len, logic [7:0] data);
    logic took;
    if (!quiet && $urandom_range(0, 99) < tx_gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.cmd            <= cmd;
    in_ch.reg_address    <= addr;
    in_ch.payload_length <= len;
    in_ch.data_byte      <= data;
    do begin
      @(negedge clk_i);
      took = in_ch.ready;
      @(posedge clk_i);
    end while (!took);
    n_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (results_pending != 0);
    @(posedge clk_i);
  endtask

  // receiver side
  initial begin
    int unsigned held;
    logic        hold_done;
    hold_done     = 1'b0;
    rx_gap_pct    = 20;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!hold_done && n_sent >= LongHoldAt) begin
        // long stall so the job queue fills and input ready drops
        hold_done     = 1'b1;
        out_ch.ready <= 1'b0;
        for (held = 0; held < LongHoldCycles; held++) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 99) < rx_gap_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
      if ($urandom_range(0, 39) == 0) begin
        rx_gap_pct = pick_gap_pct();
      end
    end
  end

  // sender side and verdict
  initial begin
    int unsigned kind;
    int unsigned len;
    int unsigned cut;
    int unsigned k;
    logic [1:0]  cmd;
    logic [7:0]  reply;
    logic        good;
    n_sent                = 0;
    n_counted             = 0;
    quiet                 = 1'b0;
    tx_gap_pct            = 20;
    in_ch.valid          <= 1'b0;
    in_ch.cmd            <= CMD_START;
    in_ch.reg_address    <= '0;
    in_ch.payload_length <= '0;
    in_ch.data_byte      <= '0;
    rst_ni               <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero-length frame: header plus CRC only
    send(CMD_START, 16'h0000, 8'd0, 8'h00);
    send(CMD_START, 16'hFFFF, 8'd1, 8'hFF);
    send(CMD_PAYLOAD, 16'hFFFF, 8'hFF, 8'hFF);
    // stray payload and unknown command are dropped
    send(CMD_PAYLOAD, 16'h0000, 8'h00, 8'h00);
    send(CMD_UNUSED, 16'hFFFF, 8'hFF, 8'hFF);
    send(CMD_START, 16'h1234, 8'd2, 8'h00);
    send(CMD_PAYLOAD, 16'h0000, 8'h00, 8'h00);
    // reply byte counted in the middle of a frame
    send(CMD_RESPONSE, 16'h0000, 8'h00, RESP_ACK);
    send(CMD_PAYLOAD, 16'h0000, 8'h00, 8'hA5);
    send(CMD_RESPONSE, 16'h0000, 8'h00, RESP_ZERO);
    send(CMD_RESPONSE, 16'h0000, 8'h00, RESP_ZERO);
    send(CMD_RESPONSE, 16'h0000, 8'h00, 8'h11);
    send(CMD_RESPONSE, 16'h0000, 8'h00, 8'h22);
    send(CMD_RESPONSE, 16'h0000, 8'h00, 8'h33);
    send(CMD_RESPONSE, 16'h0000, 8'h00, 8'h44);
    // restart clears a bad reply in progress and aborts an open frame
    send(CMD_RESPONSE, 16'h0000, 8'h00, 8'h03);
    send(CMD_START, 16'h5A5A, 8'd255, 8'h00);
    send(CMD_PAYLOAD, 16'h0000, 8'h00, 8'h80);
    send(CMD_START, 16'h00FF, 8'd0, 8'h00);
    send(CMD_RESPONSE, 16'h0000, 8'h00, RESP_ACK);
    send(CMD_RESPONSE, 16'h0000, 8'h00, 8'h01);
    for (k = 0; k < 5; k++) send(CMD_RESPONSE, 16'h0000, 8'h00, 8'(k));
    drain();

    while (n_counted < RandomItems) begin
      quiet = (n_counted >= QuietFrom);
      if ($urandom_range(0, 15) == 0) begin
        tx_gap_pct = pick_gap_pct();
      end
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len;
        send(CMD_START, 16'($urandom), 8'(len), 8'($urandom));
        n_counted++;
        for (k = 0; k < cut; k++) begin
          if ($urandom_range(0, 11) == 0) begin
            send(CMD_RESPONSE, 16'($urandom), 8'($urandom), 8'($urandom));
            n_counted++;
          end
          send(CMD_PAYLOAD, 16'($urandom), 8'($urandom), 8'($urandom));
          n_counted++;
        end
      end else if (kind < 85) begin
        for (k = 0; k < 7; k++) begin
          good = ($urandom_range(0, 3) != 0);
          case (k)
            0:       reply = good ? RESP_ACK : 8'($urandom);
            1, 2:    reply = good ? RESP_ZERO : 8'($urandom);
            default: reply = 8'($urandom);
          endcase
          send(CMD_RESPONSE, 16'($urandom), 8'($urandom), reply);
          n_counted++;
        end
      end else begin
        cmd = 2'($urandom_range(0, 3));
        send(cmd, 16'($urandom), 8'($urandom), 8'($urandom));
        n_counted++;
      end
    end

    quiet = 1'b1;
    drain();
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("register_write_frame_encoder_unit test passed");
    end else begin
      $display("register_write_frame_encoder_unit test failed");
    end
    $finish;
  end

endmodule
